[rtl/t2k_pkg.sv]
// ----------------------------------------------------------------------------
// Truss element kernel package
// Word types for both channels, pipeline depths, datapath widths and the
// signed saturation helper shared by the kernel modules.
// ----------------------------------------------------------------------------
package t2k_pkg;

    typedef struct packed {
        logic signed [31:0] x_first;
        logic signed [31:0] y_first;
        logic signed [31:0] x_second;
        logic signed [31:0] y_second;
        logic signed [31:0] disp_dx;
        logic signed [31:0] disp_dy;
        logic signed [31:0] modulus;
        logic [30:0]        area;
        logic [30:0]        density;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] stiff_cc;
        logic signed [31:0] stiff_cs;
        logic signed [31:0] stiff_ss;
        logic signed [31:0] mass_diag;
        logic signed [31:0] mass_off;
        logic [30:0]        length;
        logic signed [31:0] axial_strain;
        logic               zero_length;
    } t_out_word;

    // Square root: 65-bit radicand padded to an even width, one root bit per stage.
    localparam int ROOT_W      = 33;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SQRT_STAGES = ROOT_W;

    // Divider: 63-bit dividend, length as divisor, one quotient bit per stage.
    localparam int DEN_W      = ROOT_W;
    localparam int NUM_W      = 63;
    localparam int DIV_STAGES = NUM_W;

    // floor(q / 3) == (q * RECIP3) >> RECIP3_SHIFT for every q below 2^35.
    localparam logic [33:0] RECIP3       = 34'h2_AAAA_AAAB;
    localparam int          RECIP3_SHIFT = 35;

    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMAX = 32'h8000_0000;

    // Apply a sign to a magnitude and saturate to the signed 32-bit range.
    function automatic logic [31:0] pack_signed(input logic neg, input logic [63:0] mag);
        logic [31:0] lim;
        begin
            if (neg) begin
                lim = (mag > 64'(NMAX)) ? NMAX : mag[31:0];
                return 32'(-lim);
            end
            return (mag > 64'(SMAX)) ? SMAX : mag[31:0];
        end
    endfunction

endpackage

[rtl/t2k_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit restoring square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module t2k_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [t2k_pkg::RAD_W-1:0]    i_rad,
    output logic [t2k_pkg::ROOT_W-1:0]   o_root
);

    localparam int N  = t2k_pkg::SQRT_STAGES;
    localparam int RW = t2k_pkg::ROOT_W;
    localparam int DW = t2k_pkg::RAD_W;

    logic [RW-1:0] r_root [1:N];
    logic [RW-1:0] r_rem  [1:N];
    logic [DW-1:0] r_rad  [1:N];

    logic [RW-1:0] s_root [0:N-1];
    logic [RW-1:0] s_rem  [0:N-1];
    logic [DW-1:0] s_rad  [0:N-1];

    logic [RW-1:0] n_root [1:N];
    logic [RW-1:0] n_rem  [1:N];
    logic [DW-1:0] n_rad  [1:N];

    always_comb begin
        s_root[0] = '0;
        s_rem[0]  = '0;
        s_rad[0]  = i_rad;
        for (int k = 1; k < N; k++) begin
            s_root[k] = r_root[k];
            s_rem[k]  = r_rem[k];
            s_rad[k]  = r_rad[k];
        end
    end

    // Each stage brings down two radicand bits and tries the next root bit.
    always_comb begin
        logic [RW+1:0] rt;
        logic [RW+1:0] trial;
        logic [RW+1:0] diff;
        for (int k = 0; k < N; k++) begin
            rt    = {s_rem[k], s_rad[k][DW-1 -: 2]};
            trial = {s_root[k], 2'b01};
            diff  = rt - trial;
            if (rt >= trial) begin
                n_rem[k+1]  = diff[RW-1:0];
                n_root[k+1] = {s_root[k][RW-2:0], 1'b1};
            end else begin
                n_rem[k+1]  = rt[RW-1:0];
                n_root[k+1] = {s_root[k][RW-2:0], 1'b0};
            end
            n_rad[k+1] = {s_rad[k][DW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= N; k++) begin
                r_root[k] <= n_root[k];
                r_rem[k]  <= n_rem[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[N];

endmodule

[rtl/t2k_div.sv]
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module t2k_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [t2k_pkg::NUM_W-1:0]   i_num,
    input  logic [t2k_pkg::DEN_W-1:0]   i_den,
    output logic [t2k_pkg::NUM_W-1:0]   o_quot
);

    localparam int N  = t2k_pkg::DIV_STAGES;
    localparam int NW = t2k_pkg::NUM_W;
    localparam int DW = t2k_pkg::DEN_W;

    // The dividend shifts out at the top while quotient bits shift in below.
    logic [NW-1:0] r_nq  [1:N];
    logic [DW-1:0] r_rem [1:N];
    logic [DW-1:0] r_den [1:N];

    logic [NW-1:0] s_nq  [0:N-1];
    logic [DW-1:0] s_rem [0:N-1];
    logic [DW-1:0] s_den [0:N-1];

    logic [NW-1:0] n_nq  [1:N];
    logic [DW-1:0] n_rem [1:N];
    logic [DW-1:0] n_den [1:N];

    always_comb begin
        s_nq[0]  = i_num;
        s_rem[0] = '0;
        s_den[0] = i_den;
        for (int k = 1; k < N; k++) begin
            s_nq[k]  = r_nq[k];
            s_rem[k] = r_rem[k];
            s_den[k] = r_den[k];
        end
    end

    always_comb begin
        logic [DW:0] rt;
        logic [DW:0] diff;
        logic        ge;
        for (int k = 0; k < N; k++) begin
            rt         = {s_rem[k], s_nq[k][NW-1]};
            diff       = rt - {1'b0, s_den[k]};
            ge         = (rt >= {1'b0, s_den[k]});
            n_rem[k+1] = ge ? diff[DW-1:0] : rt[DW-1:0];
            n_nq[k+1]  = {s_nq[k][NW-2:0], ge};
            n_den[k+1] = s_den[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 1; k <= N; k++) begin
                r_nq[k]  <= n_nq[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quot = r_nq[N];

endmodule

[rtl/truss2d_element_kernel_core.sv]
// ----------------------------------------------------------------------------
// Two-node 2D truss element kernel
// Streams one truss element per cycle while not stalled and returns its
// stiffness terms, mass terms, length and axial strain in Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                Word
//   --------  ---------  -----------------------  ---------------------------
//   element   in         i_valid / o_stall        t2k_pkg::t_in_word  i_data
//   result    out        o_valid / i_stall        t2k_pkg::t_out_word o_data
//   config    in         i_cfg_valid/o_cfg_ready  mass_lumped bit i_cfg_data
//
// One word enters per cycle while the pipeline advances. The pipeline is made
// of the 33-stage square root, the two 63-stage dividers in series (direction
// cosines and stiffness, then strain), and eight stages of multiply, sum and
// saturation around them.
// Reset is synchronous and active low; it clears the valid bits of every
// stage and the mass_lumped register, not the datapath.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the result side freezes every stage in place
// and backs up onto o_stall without losing or repeating a word.
//
module truss2d_element_kernel_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t2k_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output t2k_pkg::t_out_word  o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int NS = t2k_pkg::SQRT_STAGES;
    localparam int ND = t2k_pkg::DIV_STAGES;
    localparam int LW = t2k_pkg::DEN_W;

    // Stage A: node differences in sign-magnitude form.
    typedef struct packed {
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               cneg;
        logic               sneg;
        logic               eneg;
        logic [31:0]        emag;
        logic [30:0]        area;
        logic [30:0]        rho;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
    } t_st_a;

    // Everything the square root section carries alongside the radicand.
    typedef struct packed {
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               cneg;
        logic               sneg;
        logic               eneg;
        logic [61:0]        ea;
        logic [45:0]        ra;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
    } t_sb1;

    typedef struct packed {
        logic [63:0] sqx;
        logic [63:0] sqy;
        t_sb1        sb;
    } t_st_b;

    typedef struct packed {
        logic [64:0] rad;
        t_sb1        sb;
    } t_st_c;

    // Carried alongside the cosine and stiffness dividers.
    typedef struct packed {
        logic [LW-1:0]      len;
        logic               cneg;
        logic               sneg;
        logic               eneg;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic [45:0]        ra;
    } t_sb2;

    typedef struct packed {
        logic [30:0]        cc;
        logic [30:0]        cs;
        logic [30:0]        ss;
        logic [61:0]        k;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic [LW-1:0]      len;
        logic               csneg;
        logic               eneg;
        logic [45:0]        ra;
    } t_st_e;

    // Carried alongside the strain divider.
    typedef struct packed {
        logic [30:0]   cc;
        logic [30:0]   cs;
        logic [30:0]   ss;
        logic [61:0]   k;
        logic          csneg;
        logic          eneg;
        logic          pneg;
        logic [LW-1:0] len;
        logic [45:0]   ra;
    } t_sb3;

    typedef struct packed {
        logic [62:0] pmag;
        t_sb3        sb;
    } t_st_f;

    typedef struct packed {
        logic [62:0] pl_cc;
        logic [60:0] ph_cc;
        logic [62:0] pl_cs;
        logic [60:0] ph_cs;
        logic [62:0] pl_ss;
        logic [60:0] ph_ss;
        logic        csneg;
        logic        eneg;
        logic [55:0] mpl;
        logic [55:0] mph;
        logic [31:0] strain;
        logic [30:0] len;
        logic        zl;
    } t_st_g;

    typedef struct packed {
        logic [31:0] mag_cc;
        logic [31:0] mag_cs;
        logic [31:0] mag_ss;
        logic        csneg;
        logic        eneg;
        logic        msat;
        logic [61:0] q;
        logic [31:0] strain;
        logic [30:0] len;
        logic        zl;
    } t_st_h;

    logic w_adv;

    logic r_mass_lumped;

    t_st_a r_a;
    t_st_b r_b;
    t_st_c r_c;
    t_st_e r_e;
    t_st_f r_f;
    t_st_g r_g;
    t_st_h r_h;
    t2k_pkg::t_out_word r_out;

    t_st_a n_a;
    t_st_b n_b;
    t_st_c n_c;
    t_st_e n_e;
    t_st_f n_f;
    t_st_g n_g;
    t_st_h n_h;
    t2k_pkg::t_out_word n_out;

    logic r_a_vld, r_b_vld, r_c_vld, r_e_vld, r_f_vld, r_g_vld, r_h_vld, r_out_vld;

    t_sb1 r_sb1 [0:NS-1];
    t_sb2 r_sb2 [0:ND-1];
    t_sb3 r_sb3 [0:ND-1];
    logic [NS-1:0] r_v1;
    logic [ND-1:0] r_v2;
    logic [ND-1:0] r_v3;

    t_sb2 w_sb2_in;

    logic [t2k_pkg::ROOT_W-1:0] w_root;
    logic [t2k_pkg::NUM_W-1:0]  w_quot_c;
    logic [t2k_pkg::NUM_W-1:0]  w_quot_s;
    logic [t2k_pkg::NUM_W-1:0]  w_quot_k;
    logic [t2k_pkg::NUM_W-1:0]  w_quot_p;

    // The pipeline moves as one; it only holds while a finished result waits.
    assign w_adv   = !r_out_vld || !i_stall;
    assign o_stall = !w_adv;

    assign o_valid     = r_out_vld;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass_lumped <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mass_lumped <= i_cfg_data;
        end
    end

    // Stage A: node differences, their magnitudes and the modulus magnitude.
    always_comb begin
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] ndx;
        logic signed [32:0] ndy;
        logic [31:0]        e;
        dx  = 33'(i_data.x_second) - 33'(i_data.x_first);
        dy  = 33'(i_data.y_second) - 33'(i_data.y_first);
        ndx = -dx;
        ndy = -dy;
        e   = i_data.modulus;
        n_a.cneg = dx[32];
        n_a.sneg = dy[32];
        n_a.ax   = dx[32] ? ndx[31:0] : dx[31:0];
        n_a.ay   = dy[32] ? ndy[31:0] : dy[31:0];
        n_a.eneg = e[31];
        n_a.emag = e[31] ? 32'(-e) : e;
        n_a.area = i_data.area;
        n_a.rho  = i_data.density;
        n_a.ux   = i_data.disp_dx;
        n_a.uy   = i_data.disp_dy;
    end

    // Stage B: squares for the length, E*A for stiffness, rho*A for mass.
    always_comb begin
        logic [61:0] rho_a;
        rho_a        = 62'(r_a.rho) * 62'(r_a.area);
        n_b.sqx      = 64'(r_a.ax) * 64'(r_a.ax);
        n_b.sqy      = 64'(r_a.ay) * 64'(r_a.ay);
        n_b.sb.ax    = r_a.ax;
        n_b.sb.ay    = r_a.ay;
        n_b.sb.cneg  = r_a.cneg;
        n_b.sb.sneg  = r_a.sneg;
        n_b.sb.eneg  = r_a.eneg;
        n_b.sb.ea    = 62'(r_a.emag) * 62'(r_a.area);
        n_b.sb.ra    = rho_a[61:16];
        n_b.sb.ux    = r_a.ux;
        n_b.sb.uy    = r_a.uy;
    end

    // Stage C: squared length, the radicand of the square root.
    always_comb begin
        n_c.rad = 65'(r_b.sqx) + 65'(r_b.sqy);
        n_c.sb  = r_b.sb;
    end

    t2k_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_rad  ({1'b0, r_c.rad}),
        .o_root (w_root)
    );

    // Direction cosines in Q2.30 and the axial stiffness k = E*A/Lo.
    t2k_div u_div_c (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({1'b0, r_sb1[NS-1].ax, 30'b0}),
        .i_den  (w_root),
        .o_quot (w_quot_c)
    );

    t2k_div u_div_s (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({1'b0, r_sb1[NS-1].ay, 30'b0}),
        .i_den  (w_root),
        .o_quot (w_quot_s)
    );

    t2k_div u_div_k (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  ({1'b0, r_sb1[NS-1].ea}),
        .i_den  (w_root),
        .o_quot (w_quot_k)
    );

    always_comb begin
        w_sb2_in.len  = w_root;
        w_sb2_in.cneg = r_sb1[NS-1].cneg;
        w_sb2_in.sneg = r_sb1[NS-1].sneg;
        w_sb2_in.eneg = r_sb1[NS-1].eneg;
        w_sb2_in.ux   = r_sb1[NS-1].ux;
        w_sb2_in.uy   = r_sb1[NS-1].uy;
        w_sb2_in.ra   = r_sb1[NS-1].ra;
    end

    // Stage E: products of the cosines and the displacement projection terms.
    always_comb begin
        logic [30:0]        cm;
        logic [30:0]        sm;
        logic [61:0]        pcc;
        logic [61:0]        pcs;
        logic [61:0]        pss;
        logic signed [31:0] cv;
        logic signed [31:0] sv;
        cm  = w_quot_c[30:0];
        sm  = w_quot_s[30:0];
        pcc = 62'(cm) * 62'(cm);
        pcs = 62'(cm) * 62'(sm);
        pss = 62'(sm) * 62'(sm);
        cv  = r_sb2[ND-1].cneg ? -$signed(32'(cm)) : $signed(32'(cm));
        sv  = r_sb2[ND-1].sneg ? -$signed(32'(sm)) : $signed(32'(sm));
        n_e.cc    = pcc[60:30];
        n_e.cs    = pcs[60:30];
        n_e.ss    = pss[60:30];
        n_e.k     = w_quot_k[61:0];
        n_e.px    = 64'(cv) * 64'(r_sb2[ND-1].ux);
        n_e.py    = 64'(sv) * 64'(r_sb2[ND-1].uy);
        n_e.len   = r_sb2[ND-1].len;
        n_e.csneg = r_sb2[ND-1].cneg ^ r_sb2[ND-1].sneg;
        n_e.eneg  = r_sb2[ND-1].eneg;
        n_e.ra    = r_sb2[ND-1].ra;
    end

    // Stage F: projected displacement in sign-magnitude form for the divider.
    always_comb begin
        logic signed [63:0] p;
        logic signed [63:0] np;
        p  = r_e.px + r_e.py;
        np = -p;
        n_f.pmag     = p[63] ? np[62:0] : p[62:0];
        n_f.sb.cc    = r_e.cc;
        n_f.sb.cs    = r_e.cs;
        n_f.sb.ss    = r_e.ss;
        n_f.sb.k     = r_e.k;
        n_f.sb.csneg = r_e.csneg;
        n_f.sb.eneg  = r_e.eneg;
        n_f.sb.pneg  = p[63];
        n_f.sb.len   = r_e.len;
        n_f.sb.ra    = r_e.ra;
    end

    // Strain numerator over the length.
    t2k_div u_div_p (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_num  (r_f.pmag),
        .i_den  (r_f.sb.len),
        .o_quot (w_quot_p)
    );

    // Stage G: k times the cosine products split into two halves of k, mass
    // partial products, and the finished strain.
    always_comb begin
        t_sb3 sb;
        sb = r_sb3[ND-1];
        n_g.pl_cc  = 63'(sb.k[31:0]) * 63'(sb.cc);
        n_g.ph_cc  = 61'(sb.k[61:32]) * 61'(sb.cc);
        n_g.pl_cs  = 63'(sb.k[31:0]) * 63'(sb.cs);
        n_g.ph_cs  = 61'(sb.k[61:32]) * 61'(sb.cs);
        n_g.pl_ss  = 63'(sb.k[31:0]) * 63'(sb.ss);
        n_g.ph_ss  = 61'(sb.k[61:32]) * 61'(sb.ss);
        n_g.csneg  = sb.csneg;
        n_g.eneg   = sb.eneg;
        n_g.mpl    = 56'(sb.ra[22:0]) * 56'(sb.len);
        n_g.mph    = 56'(sb.ra[45:23]) * 56'(sb.len);
        // Both truncations toward zero act on the magnitude.
        n_g.strain = t2k_pkg::pack_signed(sb.pneg, 64'(w_quot_p[62:14]));
        n_g.len    = (sb.len > LW'(t2k_pkg::SMAX)) ? t2k_pkg::SMAX[30:0] : sb.len[30:0];
        n_g.zl     = (sb.len == '0);
    end

    // Stage H: full stiffness products shifted back to Q16.16 with their
    // magnitude limit, and the element mass rho*A*Lo.
    always_comb begin
        logic [91:0] fcc;
        logic [91:0] fcs;
        logic [91:0] fss;
        logic [78:0] m;
        fcc = 92'(r_g.pl_cc) + (92'(r_g.ph_cc) << 32);
        fcs = 92'(r_g.pl_cs) + (92'(r_g.ph_cs) << 32);
        fss = 92'(r_g.pl_ss) + (92'(r_g.ph_ss) << 32);
        m   = 79'(r_g.mpl) + (79'(r_g.mph) << 23);
        n_h.mag_cc = (fcc[91:30] > 62'(t2k_pkg::NMAX)) ? t2k_pkg::NMAX : fcc[61:30];
        n_h.mag_cs = (fcs[91:30] > 62'(t2k_pkg::NMAX)) ? t2k_pkg::NMAX : fcs[61:30];
        n_h.mag_ss = (fss[91:30] > 62'(t2k_pkg::NMAX)) ? t2k_pkg::NMAX : fss[61:30];
        n_h.csneg  = r_g.csneg;
        n_h.eneg   = r_g.eneg;
        n_h.msat   = m[78];
        n_h.q      = m[77:16];
        n_h.strain = r_g.strain;
        n_h.len    = r_g.len;
        n_h.zl     = r_g.zl;
    end

    // Output stage: signs on the stiffness terms, mass split by the selected
    // scheme, and zeroing of everything for coincident nodes.
    always_comb begin
        logic [67:0] q3f;
        logic [32:0] q3;
        logic        qbig;
        logic        hbig;
        logic [31:0] diag;
        logic [31:0] off;
        q3f  = 68'(r_h.q[33:0]) * 68'(t2k_pkg::RECIP3);
        q3   = q3f[67:t2k_pkg::RECIP3_SHIFT];
        qbig = |r_h.q[61:34];
        hbig = |r_h.q[61:32];
        if (r_mass_lumped) begin
            diag = (r_h.msat || hbig) ? t2k_pkg::SMAX : {1'b0, r_h.q[31:1]};
            off  = '0;
        end else if (r_h.msat || qbig) begin
            // A mass this large saturates both the third and the sixth.
            diag = t2k_pkg::SMAX;
            off  = t2k_pkg::SMAX;
        end else begin
            diag = (q3 > 33'(t2k_pkg::SMAX)) ? t2k_pkg::SMAX : q3[31:0];
            off  = (q3[32:1] > t2k_pkg::SMAX) ? t2k_pkg::SMAX : q3[32:1];
        end
        if (r_h.zl) begin
            n_out              = '0;
            n_out.zero_length  = 1'b1;
        end else begin
            n_out.stiff_cc     = t2k_pkg::pack_signed(r_h.eneg, 64'(r_h.mag_cc));
            n_out.stiff_cs     = t2k_pkg::pack_signed(r_h.eneg ^ r_h.csneg, 64'(r_h.mag_cs));
            n_out.stiff_ss     = t2k_pkg::pack_signed(r_h.eneg, 64'(r_h.mag_ss));
            n_out.mass_diag    = diag;
            n_out.mass_off     = off;
            n_out.length       = r_h.len;
            n_out.axial_strain = r_h.strain;
            n_out.zero_length  = 1'b0;
        end
    end

    // Datapath registers and side lines; they move only when the pipe advances.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_c   <= n_c;
            r_e   <= n_e;
            r_f   <= n_f;
            r_g   <= n_g;
            r_h   <= n_h;
            r_out <= n_out;
            r_sb1[0] <= r_c.sb;
            for (int k = 1; k < NS; k++) begin
                r_sb1[k] <= r_sb1[k-1];
            end
            r_sb2[0] <= w_sb2_in;
            for (int k = 1; k < ND; k++) begin
                r_sb2[k] <= r_sb2[k-1];
            end
            r_sb3[0] <= r_f.sb;
            for (int k = 1; k < ND; k++) begin
                r_sb3[k] <= r_sb3[k-1];
            end
        end
    end

    // Valid bits travel with their words through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_v1      <= '0;
            r_v2      <= '0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_v3      <= '0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld   <= i_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_v1      <= {r_v1[NS-2:0], r_c_vld};
            r_v2      <= {r_v2[ND-2:0], r_v1[NS-1]};
            r_e_vld   <= r_v2[ND-1];
            r_f_vld   <= r_e_vld;
            r_v3      <= {r_v3[ND-2:0], r_f_vld};
            r_g_vld   <= r_v3[ND-1];
            r_h_vld   <= r_g_vld;
            r_out_vld <= r_h_vld;
        end
    end

    // Coincident nodes give a result that is zero in every numeric field.
    a_zero_len_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_length) |->
            (o_data.stiff_cc == 0 && o_data.stiff_cs == 0 && o_data.stiff_ss == 0 &&
             o_data.mass_diag == 0 && o_data.mass_off == 0 && o_data.length == 0 &&
             o_data.axial_strain == 0))
        else $error("zero-length result carries nonzero data");

    // A reported length of zero must come with the zero-length flag.
    a_len_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.zero_length) |-> (o_data.length != 0))
        else $error("nonzero-length result reports zero length");

    // Lumped mass has no coupling term.
    a_lumped_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mass_lumped) |-> (o_data.mass_off == 0))
        else $error("lumped mass result has a coupling term");

    // Consistent mass: the coupling term never exceeds the diagonal term.
    a_consistent_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_mass_lumped) |-> (o_data.mass_off <= o_data.mass_diag))
        else $error("consistent mass coupling exceeds diagonal");

    // No result leaves the pipe in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

[bench/truss2d_element_kernel_checker.sv]
// ----------------------------------------------------------------------------
// Truss element kernel checker
// Watches the element, result and config channels, predicts every result word
// from the accepted element words and compares them in order.
// ----------------------------------------------------------------------------
module truss2d_element_kernel_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_o_stall,
    input  t2k_pkg::t_in_word   i_data,
    input  logic                i_o_valid,
    input  logic                i_stall,
    input  t2k_pkg::t_out_word  i_o_data,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t2k_pkg::t_out_word pending_results[$];
    logic               lumped_mode;

    assign o_pending = pending_results.size();

    function automatic logic [31:0] sat_signed(input logic neg, input logic [127:0] mag);
        if (neg) begin
            if (mag > 128'h8000_0000) return 32'h8000_0000;
            return 32'(-mag[31:0]);
        end
        if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        r = 0;
        for (int b = 35; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (128'(t) * 128'(t) <= n) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] stiffness_term(input logic eneg, input logic [63:0] k,
                                                   input logic [63:0] prod, input logic pneg);
        logic [127:0] p;
        p = (128'(k) * 128'(prod)) >> 30;
        return sat_signed(eneg != pneg, p);
    endfunction

    function automatic t2k_pkg::t_out_word element_result(input t2k_pkg::t_in_word w,
                                                          input logic lumped);
        t2k_pkg::t_out_word r;
        logic signed [63:0] dx, dy, e, c, s, st;
        logic [63:0]        ax, ay, len, cm, sm, cc, cs, ss, k, ra, q, diag, off, ae;
        logic [127:0]       m;
        logic signed [127:0] p;
        dx = 64'(w.x_second) - 64'(w.x_first);
        dy = 64'(w.y_second) - 64'(w.y_first);
        e  = 64'(w.modulus);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        r = '0;
        len = int_sqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
        if (len == 0) begin
            r.zero_length = 1'b1;
            return r;
        end
        cm = (ax << 30) / len;
        sm = (ay << 30) / len;
        cc = (cm * cm) >> 30;
        cs = (cm * sm) >> 30;
        ss = (sm * sm) >> 30;
        ae = e < 0 ? -e : e;
        k = (ae * 64'(w.area)) / len;
        r.stiff_cc = stiffness_term(e < 0, k, cc, 1'b0);
        r.stiff_cs = stiffness_term(e < 0, k, cs, (dx < 0) != (dy < 0));
        r.stiff_ss = stiffness_term(e < 0, k, ss, 1'b0);
        ra = (64'(w.density) * 64'(w.area)) >> 16;
        m = 128'(ra) * 128'(len);
        if (m >= (128'd1 << 78)) begin
            diag = 64'h7FFF_FFFF;
            off  = lumped ? 0 : 64'h7FFF_FFFF;
        end else begin
            q = 64'(m >> 16);
            diag = lumped ? q / 2 : q / 3;
            off  = lumped ? 0 : q / 6;
            if (diag > 64'h7FFF_FFFF) diag = 64'h7FFF_FFFF;
            if (off > 64'h7FFF_FFFF) off = 64'h7FFF_FFFF;
        end
        r.mass_diag = diag[31:0];
        r.mass_off  = off[31:0];
        r.length    = len > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : len[30:0];
        c = dx < 0 ? -cm : cm;
        s = dy < 0 ? -sm : sm;
        p = 128'(c) * 128'(64'(w.disp_dx)) + 128'(s) * 128'(64'(w.disp_dy));
        p = p / $signed(128'(len));
        p = p / 128'sd16384;
        if (p > 128'sd2147483647) st = 64'sd2147483647;
        else if (p < -128'sd2147483648) st = -64'sd2147483648;
        else st = 64'(p);
        r.axial_strain = st[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t2k_pkg::t_out_word want;
        if (!i_rst_n) begin
            lumped_mode = 1'b0;
        end else begin
            if (i_o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", 32'(i_o_data.length), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_o_data.stiff_cc !== want.stiff_cc)
                        report_mismatch("stiff_cc", i_o_data.stiff_cc, want.stiff_cc);
                    if (i_o_data.stiff_cs !== want.stiff_cs)
                        report_mismatch("stiff_cs", i_o_data.stiff_cs, want.stiff_cs);
                    if (i_o_data.stiff_ss !== want.stiff_ss)
                        report_mismatch("stiff_ss", i_o_data.stiff_ss, want.stiff_ss);
                    if (i_o_data.mass_diag !== want.mass_diag)
                        report_mismatch("mass_diag", i_o_data.mass_diag, want.mass_diag);
                    if (i_o_data.mass_off !== want.mass_off)
                        report_mismatch("mass_off", i_o_data.mass_off, want.mass_off);
                    if (i_o_data.length !== want.length)
                        report_mismatch("length", 32'(i_o_data.length), 32'(want.length));
                    if (i_o_data.axial_strain !== want.axial_strain)
                        report_mismatch("axial_strain", i_o_data.axial_strain,
                                        want.axial_strain);
                    if (i_o_data.zero_length !== want.zero_length)
                        report_mismatch("zero_length", 32'(i_o_data.zero_length),
                                        32'(want.zero_length));
                end
            end
            if (i_valid && !i_o_stall)
                pending_results.push_back(element_result(i_data, lumped_mode));
            if (i_cfg_valid && i_cfg_ready)
                lumped_mode = i_cfg_data;
        end
    end

endmodule

[bench/truss2d_element_kernel_core_tb.sv]
// ----------------------------------------------------------------------------
// Truss element kernel testbench
// Drives directed and random element words through the kernel under several
// idle and stall patterns and both mass settings; the checker compares.
// ----------------------------------------------------------------------------
module truss2d_element_kernel_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 167;
    localparam int IDLE_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t2k_pkg::t_in_word  i_data;
    logic               o_valid;
    logic               i_stall;
    t2k_pkg::t_out_word o_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_data;
    int                 error_count;
    int                 pending_count;
    int                 idle_cycles;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    truss2d_element_kernel_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    truss2d_element_kernel_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_o_stall(o_stall), .i_data(i_data),
        .i_o_valid(o_valid), .i_stall(i_stall), .i_o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(error_count), .o_pending(pending_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // The receiver stalls at a rate chosen by the current phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: a long stretch with no word moving on any channel ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
            2: return 32'($signed($urandom_range(200000)) - 100000);
            default: return 32'($signed($urandom_range(64)) - 32) << 24;
        endcase
    endfunction

    function automatic t2k_pkg::t_in_word random_element();
        t2k_pkg::t_in_word w;
        w.x_first  = rand_coord();
        w.y_first  = rand_coord();
        w.x_second = ($urandom_range(15) == 0) ? w.x_first : rand_coord();
        w.y_second = ($urandom_range(15) == 0) ? w.y_first : rand_coord();
        w.disp_dx  = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(8192)) - 4096);
        w.disp_dy  = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(8192)) - 4096);
        w.modulus  = ($urandom_range(1)) ? $urandom : 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        w.area     = ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(1 << 20));
        w.density  = ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(1 << 20));
        return w;
    endfunction

    // Hand one element word to the block, holding it until it is accepted.
    // The task returns at a falling edge with valid still high; the next call
    // or the caller decides what valid does from there.
    task automatic send_element(input t2k_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The mass mode only changes once the pipeline has drained completely.
    task automatic write_mass_mode(input logic lumped);
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lumped;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_elements();
        t2k_pkg::t_in_word w;
        w = '0;
        send_element(w);
        w.x_second = 32'sd3 << 16; w.y_second = 32'sd4 << 16;
        w.disp_dx = 32'sd1 << 12; w.disp_dy = -32'sd1 << 12;
        w.modulus = 32'sd100 << 16; w.area = 31'd1 << 16; w.density = 31'd2 << 16;
        send_element(w);
        w.modulus = -32'sd100 << 16;
        send_element(w);
        w.x_first = 32'h7FFF_FFFF; w.y_first = 32'h7FFF_FFFF;
        w.x_second = 32'h8000_0000; w.y_second = 32'h8000_0000;
        w.disp_dx = 32'h7FFF_FFFF; w.disp_dy = 32'h8000_0000;
        w.modulus = 32'h8000_0000; w.area = 31'h7FFF_FFFF; w.density = 31'h7FFF_FFFF;
        send_element(w);
        w.x_first = 32'h8000_0000; w.x_second = 32'h7FFF_FFFF;
        w.y_first = 0; w.y_second = 0;
        w.modulus = 32'h7FFF_FFFF;
        send_element(w);
        w.x_first = 32'sd5; w.x_second = 32'sd5; w.y_first = -32'sd7; w.y_second = -32'sd7;
        send_element(w);
        w.x_first = 0; w.x_second = 1; w.y_second = 0;
        w.disp_dx = 32'h8000_0000; w.modulus = 32'sd1; w.area = 31'd1; w.density = 31'd1;
        send_element(w);
        w.x_second = 0; w.y_second = -32'sd1 << 16; w.disp_dy = 32'h7FFF_FFFF;
        send_element(w);
        i_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        idle_cycles = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_elements();
        write_mass_mode(1'b1);
        directed_elements();

        // Phases: none, sender idle, receiver stalling, both; mode alternates.
        for (int phase = 0; phase < 8; phase++) begin
            send_idle_pct  = (phase % 4 == 1) ? 84 : (phase % 4 == 3) ? 26 : 0;
            recv_stall_pct = (phase % 4 == 2) ? 84 : (phase % 4 == 3) ? 26 : 0;
            write_mass_mode(phase[0]);
            for (int n = 0; n < 235; n++) send_element(random_element());
            i_valid <= 1'b0;
        end

        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/t2k_pkg.sv
rtl/t2k_sqrt.sv
rtl/t2k_div.sv
rtl/truss2d_element_kernel_core.sv
bench/truss2d_element_kernel_checker.sv
bench/truss2d_element_kernel_core_tb.sv
